// ===== src/lcdns_pkg.sv =====
package lcdns_pkg;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 16;
	localparam int unsigned HOLD_W      = 16;
	localparam int unsigned COL_W       = 7;
	localparam int unsigned NIB_IDX_W   = 4;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE_PULSE = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_COMMAND_WAIT = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_CLEAR_WAIT   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_SLOW_WAIT    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_WRAP_COLUMN  = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_SECOND_LINE  = 3'd5;

	// Reset values of the configuration registers.
	localparam logic [7:0]       RST_ENABLE_PULSE = 8'd1;
	localparam logic [15:0]      RST_COMMAND_WAIT = 16'd40;
	localparam logic [15:0]      RST_CLEAR_WAIT   = 16'd2000;
	localparam logic [15:0]      RST_SLOW_WAIT    = 16'd80;
	localparam logic [COL_W-1:0] RST_WRAP_COLUMN  = 7'd16;
	localparam logic [COL_W-1:0] RST_SECOND_LINE  = 7'h40;

	localparam logic [COL_W-1:0] COL_MAX     = 7'h7F;
	localparam logic [7:0]       INSTR_CLEAR = 8'h01;

	// Nibble index of the last nibble of each request kind.
	localparam logic [NIB_IDX_W-1:0] NIB_LAST_INSTR = 4'd1;
	localparam logic [NIB_IDX_W-1:0] NIB_LAST_CHAR  = 4'd3;
	localparam logic [NIB_IDX_W-1:0] NIB_LAST_INIT  = 4'd13;
	localparam logic [NIB_IDX_W-1:0] NIB_CHAR_BYTE  = 4'd2;

	typedef enum logic [1:0] {
		REQ_INSTR = 2'd0,
		REQ_CHAR  = 2'd1,
		REQ_INIT  = 2'd2,
		REQ_NONE  = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		WAIT_NONE  = 2'd0,
		WAIT_CMD   = 2'd1,
		WAIT_CLEAR = 2'd2,
		WAIT_SLOW  = 2'd3
	} wait_sel_t;

	typedef struct packed {
		logic      rs;
		logic [3:0] nib;
		wait_sel_t wsel;
	} nib_entry_t;

	typedef struct packed {
		logic                 load;
		logic                 emit;
		logic [NIB_IDX_W-1:0] nib_idx;
		logic                 phase;
		logic                 final_step;
	} dp_cmd_t;

	typedef struct packed {
		logic                 req_ok;
		logic [NIB_IDX_W-1:0] start_idx;
		logic [NIB_IDX_W-1:0] last_idx;
		logic                 out_free;
	} dp_status_t;

	// Nibble table of every request kind. The initialization sequence is three
	// wake-up nibbles, the switch to 4-bit mode, then five instruction bytes.
	function automatic nib_entry_t nib_entry(input req_kind_t kind,
			input logic [NIB_IDX_W-1:0] idx, input logic [7:0] val,
			input logic [COL_W-1:0] line2);
		nib_entry_t e;
		logic [7:0] byte_v;
		e = '{rs: 1'b0, nib: 4'h0, wsel: WAIT_NONE};
		byte_v = 8'h00;
		unique case (kind)
			REQ_INSTR: begin
				e.nib = idx[0] ? val[3:0] : val[7:4];
				if (idx[0])
					e.wsel = (val == INSTR_CLEAR) ? WAIT_CLEAR : WAIT_CMD;
			end
			REQ_CHAR: begin
				byte_v = (idx < NIB_CHAR_BYTE) ? {1'b1, line2} : val;
				e.rs = (idx >= NIB_CHAR_BYTE);
				e.nib = idx[0] ? byte_v[3:0] : byte_v[7:4];
				if (idx[0])
					e.wsel = WAIT_CMD;
			end
			REQ_INIT: begin
				unique case (idx)
					4'd0, 4'd1, 4'd2: e.nib = 4'h3;
					4'd3: e = '{rs: 1'b0, nib: 4'h2, wsel: WAIT_CMD};
					4'd4: e.nib = 4'h2;
					4'd5: e = '{rs: 1'b0, nib: 4'h8, wsel: WAIT_CMD};
					4'd6: e.nib = 4'h0;
					4'd7: e = '{rs: 1'b0, nib: 4'h8, wsel: WAIT_CMD};
					4'd8: e.nib = 4'h0;
					4'd9: e = '{rs: 1'b0, nib: 4'h1, wsel: WAIT_CLEAR};
					4'd10: e.nib = 4'h0;
					4'd11: e = '{rs: 1'b0, nib: 4'h6, wsel: WAIT_SLOW};
					4'd12: e.nib = 4'h0;
					4'd13: e = '{rs: 1'b0, nib: 4'hC, wsel: WAIT_SLOW};
					default: e.nib = 4'h0;
				endcase
			end
			default: e.nib = 4'h0;
		endcase
		return e;
	endfunction

endpackage

// ===== src/char_lcd_nibble_write_sequencer_core.sv =====
// Character LCD 4-bit write sequencer. Each accepted request is expanded into
// pin steps (register select, D7..D4, enable level, hold time in microseconds),
// with two steps per nibble and the high nibble first. An instruction yields
// 4 steps, a string character 4, or 8 when the cursor jumps to line two, and
// the initialization request 28. The controller's step counter issues one
// step per clock while the output beat is taken; downstream stall holds it.
// Request type 3 is taken and produces no step. Configuration is written
// through cfg_we/cfg_index/cfg_data; the user must do so only while the
// block is idle, which the block itself does not enforce.
module char_lcd_nibble_write_sequencer_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lcdns_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [lcdns_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        req_type,
	input  logic [7:0]                        value,
	input  logic                              string_start,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              reg_select,
	output logic [3:0]                        data_nibble,
	output logic                              enable_level,
	output logic [lcdns_pkg::HOLD_W-1:0]      hold_us,
	output logic                              last
);

	lcdns_pkg::dp_cmd_t    cmd;
	lcdns_pkg::dp_status_t status;

	lcdns_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	lcdns_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.req_type     (req_type),
		.value        (value),
		.string_start (string_start),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.reg_select   (reg_select),
		.data_nibble  (data_nibble),
		.enable_level (enable_level),
		.hold_us      (hold_us),
		.last         (last),
		.cmd          (cmd),
		.status       (status)
	);

endmodule

// ===== src/lcdns_ctrl.sv =====
module lcdns_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  lcdns_pkg::dp_status_t   status,
	output lcdns_pkg::dp_cmd_t      cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t                          state_q;
	logic [lcdns_pkg::NIB_IDX_W-1:0] nib_idx_q;
	logic                            phase_q;
	logic                            last_nib;

	assign in_stall = (state_q != ST_IDLE);
	assign last_nib = (nib_idx_q == status.last_idx);

	always_comb begin
		cmd.load       = in_valid && (state_q == ST_IDLE);
		cmd.emit       = (state_q == ST_RUN) && status.out_free;
		cmd.nib_idx    = nib_idx_q;
		cmd.phase      = phase_q;
		cmd.final_step = phase_q && last_nib;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			nib_idx_q <= '0;
			phase_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					// An unknown request kind is taken and produces nothing.
					if (cmd.load && status.req_ok) begin
						state_q   <= ST_RUN;
						nib_idx_q <= status.start_idx;
						phase_q   <= 1'b0;
					end
				end
				ST_RUN: begin
					if (cmd.emit) begin
						if (!phase_q) begin
							phase_q <= 1'b1;
						end else if (last_nib) begin
							state_q <= ST_IDLE;
						end else begin
							nib_idx_q <= nib_idx_q + 1'b1;
							phase_q   <= 1'b0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.final_step) |=> (state_q == ST_IDLE))
		else $error("controller did not return to idle after the final step");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (nib_idx_q <= status.last_idx))
		else $error("nibble index ran past the end of the request");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && status.req_ok) |=> (state_q == ST_RUN && !phase_q))
		else $error("accepted request did not start sequencing");

endmodule

// ===== src/lcdns_dp.sv =====
module lcdns_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [lcdns_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [lcdns_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [1:0]                           req_type,
	input  logic [7:0]                           value,
	input  logic                                 string_start,
	input  logic                                 out_stall,
	output logic                                 out_valid,
	output logic                                 reg_select,
	output logic [3:0]                           data_nibble,
	output logic                                 enable_level,
	output logic [lcdns_pkg::HOLD_W-1:0]         hold_us,
	output logic                                 last,
	input  lcdns_pkg::dp_cmd_t                   cmd,
	output lcdns_pkg::dp_status_t                status
);

	logic [7:0]                        enable_pulse_q;
	logic [15:0]                       command_wait_q;
	logic [15:0]                       clear_wait_q;
	logic [15:0]                       slow_wait_q;
	logic [lcdns_pkg::COL_W-1:0]       wrap_column_q;
	logic [lcdns_pkg::COL_W-1:0]       second_line_q;
	logic [lcdns_pkg::COL_W-1:0]       column_count_q;

	lcdns_pkg::req_kind_t              kind_in;
	lcdns_pkg::req_kind_t              kind_q;
	logic [7:0]                        value_q;
	logic [lcdns_pkg::COL_W-1:0]       col_eff;
	logic                              jump;

	lcdns_pkg::nib_entry_t             entry;
	logic [15:0]                       wait_us;
	logic [lcdns_pkg::HOLD_W:0]        hold_sum;
	logic [lcdns_pkg::HOLD_W-1:0]      hold_next;
	logic                              out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_pulse_q <= lcdns_pkg::RST_ENABLE_PULSE;
			command_wait_q <= lcdns_pkg::RST_COMMAND_WAIT;
			clear_wait_q   <= lcdns_pkg::RST_CLEAR_WAIT;
			slow_wait_q    <= lcdns_pkg::RST_SLOW_WAIT;
			wrap_column_q  <= lcdns_pkg::RST_WRAP_COLUMN;
			second_line_q  <= lcdns_pkg::RST_SECOND_LINE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lcdns_pkg::CFG_ENABLE_PULSE: enable_pulse_q <= cfg_data[7:0];
				lcdns_pkg::CFG_COMMAND_WAIT: command_wait_q <= cfg_data;
				lcdns_pkg::CFG_CLEAR_WAIT:   clear_wait_q   <= cfg_data;
				lcdns_pkg::CFG_SLOW_WAIT:    slow_wait_q    <= cfg_data;
				lcdns_pkg::CFG_WRAP_COLUMN:  wrap_column_q  <= cfg_data[6:0];
				lcdns_pkg::CFG_SECOND_LINE:  second_line_q  <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// Request decode at accept time; the line-two jump is decided here.
	assign kind_in = lcdns_pkg::req_kind_t'(req_type);
	assign col_eff = string_start ? '0 : column_count_q;
	assign jump    = (col_eff == wrap_column_q);

	always_comb begin
		status.req_ok    = (kind_in != lcdns_pkg::REQ_NONE);
		status.start_idx = (kind_in == lcdns_pkg::REQ_CHAR && !jump) ?
			lcdns_pkg::NIB_CHAR_BYTE : '0;
		status.out_free  = !out_valid_q || !out_stall;
		unique case (kind_q)
			lcdns_pkg::REQ_INSTR: status.last_idx = lcdns_pkg::NIB_LAST_INSTR;
			lcdns_pkg::REQ_CHAR:  status.last_idx = lcdns_pkg::NIB_LAST_CHAR;
			lcdns_pkg::REQ_INIT:  status.last_idx = lcdns_pkg::NIB_LAST_INIT;
			default:              status.last_idx = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= '0;
			kind_q         <= lcdns_pkg::REQ_NONE;
		end else if (cmd.load) begin
			kind_q <= kind_in;
			if (kind_in == lcdns_pkg::REQ_CHAR)
				column_count_q <= (col_eff == lcdns_pkg::COL_MAX) ? col_eff :
					col_eff + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			value_q <= value;
	end

	// Step payload: the wait only lands on the enable-low step of a nibble.
	always_comb begin
		entry = lcdns_pkg::nib_entry(kind_q, cmd.nib_idx, value_q, second_line_q);
		case (entry.wsel)
			lcdns_pkg::WAIT_CMD:   wait_us = command_wait_q;
			lcdns_pkg::WAIT_CLEAR: wait_us = clear_wait_q;
			lcdns_pkg::WAIT_SLOW:  wait_us = slow_wait_q;
			default:               wait_us = '0;
		endcase
		if (!cmd.phase)
			wait_us = '0;
		hold_sum  = {9'd0, enable_pulse_q} + {1'b0, wait_us};
		hold_next = hold_sum[lcdns_pkg::HOLD_W] ? '1 : hold_sum[lcdns_pkg::HOLD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			reg_select   <= entry.rs;
			data_nibble  <= entry.nib;
			enable_level <= !cmd.phase;
			hold_us      <= hold_next;
			last         <= cmd.final_step;
		end
	end

	assign out_valid = out_valid_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> status.out_free)
		else $error("step written over a beat still waiting downstream");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && kind_q == lcdns_pkg::REQ_CHAR && cmd.nib_idx < lcdns_pkg::NIB_CHAR_BYTE)
		|=> !reg_select)
		else $error("line-two address sent on the data register");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;

	localparam int          RESET_CYCLES    = 11;
	localparam int          MAX_IDLE        = 13;
	localparam int          HOLD_OFF_CYCLES = 300;
	localparam int          SETTLE_CYCLES   = 8;
	localparam int          DRAIN_CYCLES    = 32;
	localparam int          LONG_STRING     = 130;
	localparam int unsigned TIMEOUT_NS      = 10_000_000;

	// Register slots past the end of the list; writes there must be ignored.
	localparam logic [lcdns_pkg::CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [lcdns_pkg::CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;

	localparam logic [3:0] WAKE_NIB      = 4'h3;
	localparam logic [3:0] MODE4_NIB     = 4'h2;
	localparam logic [7:0] FUNC_SET_4BIT = 8'h28;
	localparam logic [7:0] DISPLAY_OFF   = 8'h08;
	localparam logic [7:0] ENTRY_MODE    = 8'h06;
	localparam logic [7:0] DISPLAY_ON    = 8'h0C;
	localparam logic [7:0] SET_DDRAM     = 8'h80;

	typedef struct packed {
		logic        rs;
		logic [3:0]  nib;
		logic        en;
		logic [15:0] hold;
		logic        last;
	} lcd_step_t;

	typedef struct packed {
		lcdns_pkg::req_kind_t kind;
		logic [7:0]           val;
		logic                 first;
		logic                 typed;
		logic [15:0]          final_hold;
	} script_row_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [lcdns_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [lcdns_pkg::CFG_DATA_W-1:0]  cfg_data;
	logic              in_valid;
	logic              in_stall;
	logic [1:0]        req_type;
	logic [7:0]        value;
	logic              string_start;
	logic              out_valid;
	logic              out_stall;
	logic              reg_select;
	logic [3:0]        data_nibble;
	logic              enable_level;
	logic [lcdns_pkg::HOLD_W-1:0] hold_us;
	logic              last;

	// Typed-in expectation that travels with the request being offered.
	logic              row_typed;
	logic [15:0]       row_final_hold;

	// Mirror of the block's registers and column counter.
	logic [7:0]        cfg_pulse;
	logic [15:0]       cfg_cmd_wait;
	logic [15:0]       cfg_clear_wait;
	logic [15:0]       cfg_slow_wait;
	logic [lcdns_pkg::COL_W-1:0] cfg_wrap;
	logic [lcdns_pkg::COL_W-1:0] cfg_line2;
	logic [lcdns_pkg::COL_W-1:0] col_count;

	lcd_step_t         pending_steps[$];
	int unsigned       mismatches = 0;
	int                max_gap_in  = MAX_IDLE;
	int                max_gap_out = MAX_IDLE;
	bit                hold_off_req = 1'b0;

	// Runs at the reset configuration; instruction and no-op rows are typed in.
	script_row_t script [17] = '{
		'{lcdns_pkg::REQ_INIT,  8'h00, 1'b0, 1'b0, 16'd0},
		'{lcdns_pkg::REQ_INSTR, 8'h00, 1'b0, 1'b1, 16'd41},
		'{lcdns_pkg::REQ_INSTR, 8'hFF, 1'b1, 1'b1, 16'd41},
		'{lcdns_pkg::REQ_INSTR, 8'h01, 1'b0, 1'b1, 16'd2001},
		'{lcdns_pkg::REQ_INSTR, 8'h80, 1'b0, 1'b1, 16'd41},
		'{lcdns_pkg::REQ_NONE,  8'hA5, 1'b1, 1'b1, 16'd0},
		'{lcdns_pkg::REQ_CHAR,  8'h41, 1'b1, 1'b0, 16'd0},
		'{lcdns_pkg::REQ_CHAR,  8'hFF, 1'b0, 1'b0, 16'd0},
		'{lcdns_pkg::REQ_CHAR,  8'h00, 1'b0, 1'b0, 16'd0},
		'{lcdns_pkg::REQ_NONE,  8'h5A, 1'b1, 1'b1, 16'd0},
		'{lcdns_pkg::REQ_CHAR,  8'h7E, 1'b0, 1'b0, 16'd0},
		'{lcdns_pkg::REQ_INSTR, 8'h01, 1'b1, 1'b1, 16'd2001},
		'{lcdns_pkg::REQ_CHAR,  8'h30, 1'b0, 1'b0, 16'd0},
		'{lcdns_pkg::REQ_CHAR,  8'h20, 1'b1, 1'b0, 16'd0},
		'{lcdns_pkg::REQ_CHAR,  8'h55, 1'b0, 1'b0, 16'd0},
		'{lcdns_pkg::REQ_INIT,  8'hFF, 1'b1, 1'b0, 16'd0},
		'{lcdns_pkg::REQ_INSTR, 8'h0C, 1'b0, 1'b1, 16'd41}
	};

	char_lcd_nibble_write_sequencer_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.value        (value),
		.string_start (string_start),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.reg_select   (reg_select),
		.data_nibble  (data_nibble),
		.enable_level (enable_level),
		.hold_us      (hold_us),
		.last         (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [15:0] sat_hold(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[16] ? 16'hFFFF : sum[15:0];
	endfunction

	function automatic void push_step(input logic rs, input logic [3:0] nib, input logic en,
			input logic [15:0] hold);
		lcd_step_t s;
		s.rs   = rs;
		s.nib  = nib;
		s.en   = en;
		s.hold = hold;
		s.last = 1'b0;
		pending_steps.push_back(s);
	endfunction

	// One enable pulse; the wait after it rides on the enable-low hold.
	function automatic void push_nibble(input logic rs, input logic [3:0] nib,
			input logic [15:0] extra_us);
		push_step(rs, nib, 1'b1, 16'(cfg_pulse));
		push_step(rs, nib, 1'b0, sat_hold(16'(cfg_pulse), extra_us));
	endfunction

	function automatic void push_byte(input logic rs, input logic [7:0] b,
			input logic [15:0] extra_us);
		push_nibble(rs, b[7:4], 16'd0);
		push_nibble(rs, b[3:0], extra_us);
	endfunction

	function automatic void expand_request(input lcdns_pkg::req_kind_t kind,
			input logic [7:0] v, input logic first);
		int unsigned n0;
		n0 = pending_steps.size();
		case (kind)
			lcdns_pkg::REQ_INSTR: begin
				push_byte(1'b0, v,
					(v == lcdns_pkg::INSTR_CLEAR) ? cfg_clear_wait : cfg_cmd_wait);
			end
			lcdns_pkg::REQ_CHAR: begin
				if (first)
					col_count = '0;
				if (col_count == cfg_wrap)
					push_byte(1'b0, SET_DDRAM | {1'b0, cfg_line2}, cfg_cmd_wait);
				push_byte(1'b1, v, cfg_cmd_wait);
				// The counter sticks at its top value.
				if (col_count != lcdns_pkg::COL_MAX)
					col_count = col_count + 1'b1;
			end
			lcdns_pkg::REQ_INIT: begin
				push_nibble(1'b0, WAKE_NIB, 16'd0);
				push_nibble(1'b0, WAKE_NIB, 16'd0);
				push_nibble(1'b0, WAKE_NIB, 16'd0);
				push_nibble(1'b0, MODE4_NIB, cfg_cmd_wait);
				push_byte(1'b0, FUNC_SET_4BIT, cfg_cmd_wait);
				push_byte(1'b0, DISPLAY_OFF, cfg_cmd_wait);
				push_byte(1'b0, lcdns_pkg::INSTR_CLEAR, cfg_clear_wait);
				push_byte(1'b0, ENTRY_MODE, cfg_slow_wait);
				push_byte(1'b0, DISPLAY_ON, cfg_slow_wait);
			end
			default: begin
			end
		endcase
		if (pending_steps.size() > n0)
			pending_steps[pending_steps.size() - 1].last = 1'b1;
	endfunction

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : monitor
		lcd_step_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				if (!row_typed) begin
					expand_request(lcdns_pkg::req_kind_t'(req_type), value, string_start);
				end else if (lcdns_pkg::req_kind_t'(req_type) == lcdns_pkg::REQ_INSTR) begin
					push_step(1'b0, value[7:4], 1'b1, 16'(lcdns_pkg::RST_ENABLE_PULSE));
					push_step(1'b0, value[7:4], 1'b0, 16'(lcdns_pkg::RST_ENABLE_PULSE));
					push_step(1'b0, value[3:0], 1'b1, 16'(lcdns_pkg::RST_ENABLE_PULSE));
					push_step(1'b0, value[3:0], 1'b0, row_final_hold);
					pending_steps[pending_steps.size() - 1].last = 1'b1;
				end
			end
			if (out_valid && !out_stall) begin
				if (pending_steps.size() == 0) begin
					$error("step beat with nothing pending: rs %0d nibble %0h hold %0d",
						reg_select, data_nibble, hold_us);
					mismatches++;
				end else begin
					want = pending_steps.pop_front();
					check_field("reg_select", 16'(want.rs), 16'(reg_select));
					check_field("data_nibble", 16'(want.nib), 16'(data_nibble));
					check_field("enable_level", 16'(want.en), 16'(enable_level));
					check_field("hold_us", want.hold, hold_us);
					check_field("last", 16'(want.last), 16'(last));
				end
			end
		end
	end

	initial begin : receiver
		int n;
		out_stall = 1'b0;
		wait (arst_n);
		forever begin
			if (hold_off_req) begin
				n = HOLD_OFF_CYCLES;
				hold_off_req = 1'b0;
			end else begin
				n = $urandom_range(0, max_gap_out);
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic send_req(input lcdns_pkg::req_kind_t kind, input logic [7:0] v,
			input logic first, input logic typed, input logic [15:0] final_hold);
		int gap;
		gap = $urandom_range(0, max_gap_in);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1'b1;
		req_type       <= kind;
		value          <= v;
		string_start   <= first;
		row_typed      <= typed;
		row_final_hold <= final_hold;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_item(input lcdns_pkg::req_kind_t kind, input logic [7:0] v,
			input logic first);
		send_req(kind, v, first, 1'b0, 16'd0);
	endtask

	// Returns once every pending step is out and the block has had time to go idle.
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_steps.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [lcdns_pkg::CFG_INDEX_W-1:0] idx,
			input logic [15:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			lcdns_pkg::CFG_ENABLE_PULSE: cfg_pulse      = data[7:0];
			lcdns_pkg::CFG_COMMAND_WAIT: cfg_cmd_wait   = data;
			lcdns_pkg::CFG_CLEAR_WAIT:   cfg_clear_wait = data;
			lcdns_pkg::CFG_SLOW_WAIT:    cfg_slow_wait  = data;
			lcdns_pkg::CFG_WRAP_COLUMN:  cfg_wrap       = data[lcdns_pkg::COL_W-1:0];
			lcdns_pkg::CFG_SECOND_LINE:  cfg_line2      = data[lcdns_pkg::COL_W-1:0];
			default: begin
			end
		endcase
	endtask

	task automatic configure(input logic [15:0] pulse, input logic [15:0] cmd,
			input logic [15:0] clr, input logic [15:0] slow, input logic [15:0] wrap,
			input logic [15:0] line2);
		settle();
		write_reg(CFG_SPARE_LO, 16'($urandom));
		write_reg(lcdns_pkg::CFG_ENABLE_PULSE, pulse);
		write_reg(lcdns_pkg::CFG_COMMAND_WAIT, cmd);
		write_reg(lcdns_pkg::CFG_CLEAR_WAIT, clr);
		write_reg(lcdns_pkg::CFG_SLOW_WAIT, slow);
		write_reg(lcdns_pkg::CFG_WRAP_COLUMN, wrap);
		write_reg(lcdns_pkg::CFG_SECOND_LINE, line2);
		write_reg(CFG_SPARE_HI, 16'($urandom));
		cfg_we <= 1'b0;
	endtask

	// Mostly whole strings with a start flag on the first character; the start
	// flag is occasionally misplaced.
	task automatic run_traffic(input int n_items);
		int sent;
		int pick;
		int len;
		logic [7:0] v;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				len = $urandom_range(1, 20);
				for (int k = 0; k < len; k++)
					send_item(lcdns_pkg::REQ_CHAR, 8'($urandom),
						(k == 0) ^ ($urandom_range(0, 19) == 0));
				sent += len;
			end else if (pick < 80) begin
				v = ($urandom_range(0, 9) == 0) ? lcdns_pkg::INSTR_CLEAR : 8'($urandom);
				send_item(lcdns_pkg::REQ_INSTR, v, 1'($urandom));
				sent++;
			end else if (pick < 90) begin
				send_item(lcdns_pkg::REQ_INIT, 8'($urandom), 1'($urandom));
				sent++;
			end else begin
				send_item(lcdns_pkg::REQ_NONE, 8'($urandom), 1'($urandom));
			end
		end
	endtask

	initial begin : stimulus
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = lcdns_pkg::CFG_ENABLE_PULSE;
		cfg_data       = '0;
		in_valid       = 1'b0;
		req_type       = lcdns_pkg::REQ_NONE;
		value          = '0;
		string_start   = 1'b0;
		row_typed      = 1'b0;
		row_final_hold = '0;
		cfg_pulse      = lcdns_pkg::RST_ENABLE_PULSE;
		cfg_cmd_wait   = lcdns_pkg::RST_COMMAND_WAIT;
		cfg_clear_wait = lcdns_pkg::RST_CLEAR_WAIT;
		cfg_slow_wait  = lcdns_pkg::RST_SLOW_WAIT;
		cfg_wrap       = lcdns_pkg::RST_WRAP_COLUMN;
		cfg_line2      = lcdns_pkg::RST_SECOND_LINE;
		col_count      = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i])
			send_req(script[i].kind, script[i].val, script[i].first, script[i].typed,
				script[i].final_hold);

		// Everything at its top value: holds saturate and a long string pins the
		// column counter, so every character past the wrap point jumps again.
		configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		for (int k = 0; k < LONG_STRING; k++)
			send_item(lcdns_pkg::REQ_CHAR, 8'($urandom), k == 0);
		run_traffic(20);

		// Zero pulse and waits; a zero wrap column jumps before the first character.
		configure(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		max_gap_in  = 0;
		max_gap_out = 0;
		run_traffic(40);

		for (int p = 0; p < 5; p++) begin
			configure(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
				$urandom_range(0, 1) ? {9'($urandom), 7'($urandom_range(1, 8))}
					: 16'($urandom),
				16'($urandom));
			max_gap_in  = (p == 1 || p == 2) ? 0 : MAX_IDLE;
			max_gap_out = (p == 3) ? 0 : MAX_IDLE;
			if (p == 2)
				hold_off_req = 1'b1;
			run_traffic(45);
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("tb: failure");
		$finish;
	end

endmodule

// ===== files.f =====
src/lcdns_pkg.sv
src/lcdns_ctrl.sv
src/lcdns_dp.sv
src/char_lcd_nibble_write_sequencer_core.sv
dv/tb.sv
